### hdl/running_median_two_heaps_top_defines.svh
// Assertion macros for the running median block
`ifndef RUNNING_MEDIAN_TWO_HEAPS_TOP_DEFINES_SVH
`define RUNNING_MEDIAN_TWO_HEAPS_TOP_DEFINES_SVH
// implication checked at every clock edge outside reset
`define RMH_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");
// next-cycle implication
`define RMH_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");
`endif

### hdl/rmh_pkg.sv
// Package: widths, constants and sequencer states for the running median
package rmh_pkg;
    localparam int Capacity   = 1024;
    localparam int SampleBits = 16;
    localparam int HeapDepth  = (Capacity + 1) / 2;
    localparam int AddrBits   = $clog2(HeapDepth);
    localparam int SizeBits   = $clog2(HeapDepth + 1);
    localparam int CountBits  = 11;
    localparam int MedBits    = SampleBits + 1;

    typedef logic signed [SampleBits-1:0] t_sample;
    typedef logic [AddrBits-1:0]          t_addr;
    typedef logic [SizeBits-1:0]          t_size;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_TOPS,
        ST_DECIDE,
        ST_DN_RD,
        ST_DN_CMP,
        ST_UP_RD,
        ST_UP_CMP,
        ST_MED_RD,
        ST_OUT
    } t_state;

    // one heap port request
    typedef struct packed {
        logic  we;
        t_addr waddr;
        t_sample wdata;
        t_addr raddr0;
        t_addr raddr1;
    } t_heap_req;
endpackage

### hdl/rmh_stream_if.sv
// Valid/ready channel interfaces for input samples and results
interface rmh_in_if;
    import rmh_pkg::*;
    logic    valid;
    logic    ready;
    t_sample sample;
    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

interface rmh_out_if;
    import rmh_pkg::*;
    logic                      valid;
    logic                      ready;
    logic signed [MedBits-1:0] median_doubled;
    logic [CountBits-1:0]      item_count;
    logic                      overflow;
    modport source (output valid, output median_doubled, output item_count,
                    output overflow, input ready);
    modport sink   (input valid, input median_doubled, input item_count,
                    input overflow, output ready);
endinterface

### hdl/running_median_two_heaps_top.sv
// Top level: running median over two heaps held in block RAM
// One sample per beat; each beat, accept through output beat, runs a decide step,
// an optional sift-down walk and a sift-up walk over the heap RAMs, one level per
// read and compare state pair each, then median read and output steps. Overflowing
// samples skip both walks. Only one sample is in flight at a time.
module running_median_two_heaps_top (
    input  logic      i_clk,
    input  logic      i_rst_n,
    rmh_in_if.sink    in_ch,
    rmh_out_if.source out_ch
);
    import rmh_pkg::*;
    t_heap_req w_lo_req, w_up_req;
    t_sample   w_lo_rd0, w_lo_rd1, w_up_rd0, w_up_rd1;

    rmh_ctrl u_ctrl (
        .i_clk, .i_rst_n, .in_ch, .out_ch,
        .o_lo_req(w_lo_req), .o_up_req(w_up_req),
        .i_lo_rd0(w_lo_rd0), .i_lo_rd1(w_lo_rd1),
        .i_up_rd0(w_up_rd0), .i_up_rd1(w_up_rd1)
    );
    rmh_heap_ram u_lo (.i_clk, .i_req(w_lo_req), .o_rdata0(w_lo_rd0), .o_rdata1(w_lo_rd1));
    rmh_heap_ram u_up (.i_clk, .i_req(w_up_req), .o_rdata0(w_up_rd0), .o_rdata1(w_up_rd1));
endmodule

### hdl/rmh_heap_ram.sv
// Heap store: one write port, two registered read ports
module rmh_heap_ram (
    input  logic                i_clk,
    input  rmh_pkg::t_heap_req  i_req,
    output rmh_pkg::t_sample    o_rdata0,
    output rmh_pkg::t_sample    o_rdata1
);
    import rmh_pkg::*;
    t_sample r_mem [HeapDepth];

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
        o_rdata0 <= r_mem[i_req.raddr0];
        o_rdata1 <= r_mem[i_req.raddr1];
    end
endmodule

### hdl/rmh_ctrl.sv
// Insert sequencer: decides the move, walks sift-down then sift-up
module rmh_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    rmh_in_if.sink             in_ch,
    rmh_out_if.source          out_ch,
    output rmh_pkg::t_heap_req o_lo_req,
    output rmh_pkg::t_heap_req o_up_req,
    input  rmh_pkg::t_sample   i_lo_rd0,
    input  rmh_pkg::t_sample   i_lo_rd1,
    input  rmh_pkg::t_sample   i_up_rd0,
    input  rmh_pkg::t_sample   i_up_rd1
);
    import rmh_pkg::*;

    t_state  r_state, n_state;
    t_size   r_lo_size, n_lo_size, r_up_size, n_up_size;
    t_sample r_v, n_v;            // value being placed in current walk
    t_sample r_moved, n_moved;    // value to push afterwards
    logic    r_dn_lo, n_dn_lo;    // sift-down acts on lower heap
    logic    r_up_lo, n_up_lo;    // sift-up acts on lower heap
    logic    r_do_dn, n_do_dn;
    t_size   r_idx, n_idx;        // current hole position
    t_size   r_lim, n_lim;
    logic    r_ovf, n_ovf;
    logic [CountBits-1:0]       r_cnt, n_cnt;

    logic [SizeBits:0] w_total;
    logic [SizeBits:0] w_c1, w_c2;
    t_size   w_par;
    t_sample w_dn_c1, w_dn_c2, w_up_p;
    t_heap_req w_req;
    logic    w_req_lo;

    assign w_total = {1'b0, r_lo_size} + {1'b0, r_up_size};
    assign w_c1    = {r_idx, 1'b1};
    assign w_c2    = w_c1 + 1'b1;
    assign w_par   = (r_idx - 1'b1) >> 1;
    assign w_dn_c1 = r_dn_lo ? i_lo_rd0 : i_up_rd0;
    assign w_dn_c2 = r_dn_lo ? i_lo_rd1 : i_up_rd1;
    assign w_up_p  = r_up_lo ? i_lo_rd0 : i_up_rd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_lo_size <= '0;
            r_up_size <= '0;
        end else begin
            r_state   <= n_state;
            r_lo_size <= n_lo_size;
            r_up_size <= n_up_size;
        end
        r_v     <= n_v;
        r_moved <= n_moved;
        r_dn_lo <= n_dn_lo;
        r_up_lo <= n_up_lo;
        r_do_dn <= n_do_dn;
        r_idx   <= n_idx;
        r_lim   <= n_lim;
        r_ovf   <= n_ovf;
        r_cnt   <= n_cnt;
    end

    always_comb begin
        logic    l_take2;
        t_sample l_best;
        n_state   = r_state;
        n_lo_size = r_lo_size;
        n_up_size = r_up_size;
        n_v       = r_v;
        n_moved   = r_moved;
        n_dn_lo   = r_dn_lo;
        n_up_lo   = r_up_lo;
        n_do_dn   = r_do_dn;
        n_idx     = r_idx;
        n_lim     = r_lim;
        n_ovf     = r_ovf;
        n_cnt     = r_cnt;
        w_req     = '0;
        w_req_lo  = 1'b0;
        l_take2   = 1'b0;
        l_best    = '0;
        in_ch.ready  = 1'b0;
        out_ch.valid = 1'b0;

        case (r_state)
            ST_IDLE: begin
                in_ch.ready = 1'b1;
                if (in_ch.valid) begin
                    n_v     = in_ch.sample;
                    n_state = ST_TOPS;
                end
            end
            ST_TOPS: begin
                // read both tops
                n_state = ST_DECIDE;
            end
            ST_DECIDE: begin
                n_ovf = 1'b0;
                if (w_total >= (SizeBits+1)'(Capacity)) begin
                    n_ovf   = 1'b1;
                    n_state = ST_MED_RD;
                end else if (r_lo_size == r_up_size) begin
                    n_up_lo = 1'b1;
                    n_lo_size = r_lo_size + 1'b1;
                    if (r_lo_size != '0 && r_v > i_up_rd0) begin
                        n_moved = i_up_rd0;
                        n_dn_lo = 1'b0;
                        n_do_dn = 1'b1;
                        n_lim   = r_up_size;
                    end else begin
                        n_moved = r_v;
                        n_do_dn = 1'b0;
                    end
                    n_state = ST_DN_RD;
                end else begin
                    n_up_lo = 1'b0;
                    n_up_size = r_up_size + 1'b1;
                    if (r_v < i_lo_rd0) begin
                        n_moved = i_lo_rd0;
                        n_dn_lo = 1'b1;
                        n_do_dn = 1'b1;
                        n_lim   = r_lo_size;
                    end else begin
                        n_moved = r_v;
                        n_do_dn = 1'b0;
                    end
                    n_state = ST_DN_RD;
                end
                n_idx = '0;
            end
            ST_DN_RD: begin
                if (!r_do_dn) begin
                    // start sift-up of moved at old size of target heap
                    n_idx   = r_up_lo ? r_lo_size - 1'b1 : r_up_size - 1'b1;
                    n_v     = r_moved;
                    n_state = ST_UP_RD;
                end else if (w_c1 >= {1'b0, r_lim}) begin
                    w_req_lo    = r_dn_lo;
                    w_req.we    = 1'b1;
                    w_req.waddr = t_addr'(r_idx);
                    w_req.wdata = r_v;
                    n_do_dn     = 1'b0;
                end else begin
                    w_req_lo     = r_dn_lo;
                    w_req.raddr0 = t_addr'(w_c1);
                    w_req.raddr1 = t_addr'(w_c2);
                    n_state      = ST_DN_CMP;
                end
            end
            ST_DN_CMP: begin
                if (w_c2 < {1'b0, r_lim}) begin
                    l_take2 = r_dn_lo ? (w_dn_c2 > w_dn_c1) : (w_dn_c2 < w_dn_c1);
                end
                l_best   = l_take2 ? w_dn_c2 : w_dn_c1;
                w_req_lo = r_dn_lo;
                w_req.we = 1'b1;
                n_state  = ST_DN_RD;
                if (r_dn_lo ? (l_best > r_v) : (l_best < r_v)) begin
                    w_req.waddr = t_addr'(r_idx);
                    w_req.wdata = l_best;
                    n_idx = l_take2 ? t_size'(w_c2) : t_size'(w_c1);
                end else begin
                    w_req.waddr = t_addr'(r_idx);
                    w_req.wdata = r_v;
                    n_do_dn     = 1'b0;
                end
            end
            ST_UP_RD: begin
                w_req_lo = r_up_lo;
                if (r_idx == '0) begin
                    w_req.we    = 1'b1;
                    w_req.waddr = '0;
                    w_req.wdata = r_v;
                    n_state     = ST_MED_RD;
                end else begin
                    w_req.raddr0 = t_addr'(w_par);
                    n_state      = ST_UP_CMP;
                end
            end
            ST_UP_CMP: begin
                w_req_lo = r_up_lo;
                w_req.we = 1'b1;
                w_req.waddr = t_addr'(r_idx);
                if (r_up_lo ? (r_v > w_up_p) : (r_v < w_up_p)) begin
                    w_req.wdata = w_up_p;
                    n_idx       = w_par;
                    n_state     = ST_UP_RD;
                end else begin
                    w_req.wdata = r_v;
                    n_state     = ST_MED_RD;
                end
            end
            ST_MED_RD: begin
                // tops read here appear next cycle
                n_state = ST_OUT;
                n_cnt   = CountBits'(w_total);
            end
            ST_OUT: begin
                out_ch.valid = 1'b1;
                if (out_ch.ready) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // median from tops registered in ST_OUT's first cycle
    logic signed [MedBits-1:0] w_med;
    logic r_med_ld;
    always_ff @(posedge i_clk) begin
        r_med_ld <= (r_state == ST_MED_RD);
    end
    assign w_med = (r_lo_size > r_up_size)
                 ? {i_lo_rd0, 1'b0}
                 : MedBits'(i_lo_rd0) + MedBits'(i_up_rd0);

    logic signed [MedBits-1:0] r_med_hold;
    always_ff @(posedge i_clk) begin
        if (r_med_ld) begin
            r_med_hold <= w_med;
        end
    end

    assign out_ch.median_doubled = r_med_ld ? w_med : r_med_hold;
    assign out_ch.item_count     = r_cnt;
    assign out_ch.overflow       = r_ovf;

    always_comb begin
        o_lo_req = '0;
        o_up_req = '0;
        if (w_req_lo) begin
            o_lo_req = w_req;
        end else begin
            o_up_req = w_req;
        end
        // tops on port 0 whenever no walk reads
        if (r_state == ST_IDLE || r_state == ST_TOPS || r_state == ST_MED_RD
            || r_state == ST_OUT) begin
            o_lo_req.raddr0 = '0;
            o_up_req.raddr0 = '0;
        end
    end
endmodule

### hdl/rmh_checker.sv
// Port-level checks for the running median, bound to the top level
`include "running_median_two_heaps_top_defines.svh"
module rmh_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic in_valid,
    input logic in_ready,
    input logic out_valid,
    input logic out_ready,
    input logic [10:0] out_count,
    input logic out_overflow
);
    `RMH_ASSERT_NXT(a_out_holds, i_clk, i_rst_n, out_valid && !out_ready, out_valid)
    `RMH_ASSERT_IMP(a_no_overlap, i_clk, i_rst_n, out_valid, !in_ready)
    `RMH_ASSERT_IMP(a_count_nonzero, i_clk, i_rst_n, out_valid, out_count != 11'd0)
    `RMH_ASSERT_IMP(a_ovf_full, i_clk, i_rst_n, out_valid && out_overflow, out_count == 11'd1024)
endmodule

bind running_median_two_heaps_top rmh_checker u_rmh_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n),
    .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .out_count(out_ch.item_count), .out_overflow(out_ch.overflow)
);
